// File: hw/rtl/dq_pkg.sv
// shared types and constants for the double-ended queue core
`timescale 1ns / 1ps

package dq_pkg;

   // default number of entries
   localparam int DEPTH_DEFAULT = 16;

   // fixed field widths
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   // stream data widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_LIST_FWD   = 3'd4,
      ACT_LIST_BWD   = 3'd5
   } action_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   // per-cycle operation broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD    = 2'd0,
      CELL_SHIFT_R = 2'd1,
      CELL_SHIFT_L = 2'd2,
      CELL_LOAD    = 2'd3
   } cell_op_type;

   // control group from the sequencer to the cell row
   typedef struct packed {
      cell_op_type op;
      logic        rotate;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/dq_cell.sv
// one storage cell of the queue row; moves its value to or from its neighbors
`timescale 1ns / 1ps

module dq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                          clock,
   input  dq_pkg::cell_ctrl_type         ctrl,
   input  logic [CNT_W-1:0]              count,
   input  logic [dq_pkg::VALUE_W-1:0]    left_value,
   input  logic [dq_pkg::VALUE_W-1:0]    right_value,
   input  logic [dq_pkg::VALUE_W-1:0]    head_value,
   input  logic [dq_pkg::VALUE_W-1:0]    push_value,
   output logic [dq_pkg::VALUE_W-1:0]    value
);
   import dq_pkg::*;

   localparam logic [CNT_W-1:0] POS_FREE = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] POS_TAIL = CNT_W'(INDEX + 1);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               is_tail;
   logic               is_free;

   // position of this cell relative to the occupied range
   assign is_tail = (count == POS_TAIL);
   assign is_free = (count == POS_FREE);

   // next value from the broadcast operation
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_SHIFT_R: begin
            value_in = left_value;
         end
         CELL_SHIFT_L: begin
            // the tail cell closes the ring when rotating
            value_in = (ctrl.rotate && is_tail) ? head_value : right_value;
         end
         CELL_LOAD: begin
            value_in = is_free ? push_value : value_ff;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// top level of the double-ended queue: request sequencer, cell row and result register
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a row of DEPTH cells,
// the front at cell 0. Requests arrive on the req_ stream: push front, push back,
// pop front, pop back, list front to back, list back to front. Results leave on the
// rsp_ stream; rsp_tlast marks the final result of each request.
// Pushes and pops give one result each, so with a ready receiver one such request
// is taken every cycle; the front is read at cell 0, the back through a select on
// the tail cell. Push front and pop front shift the row, push back loads the free
// cell after the tail and pop back moves nothing. While listing N values, each cycle
// with no receiver stall rotates the row by one cell and sends the value at its end,
// so after N steps the row is back in place. No request is taken until listing ends.
// Empty pops and listings give a single empty status; a push into a full queue is
// dropped with a full status. Unused action codes are taken and give no result.
// Results sit in one output register: while the receiver stalls, the block holds
// the pending result, takes no new request and pauses any listing.
// Reset clears the occupancy, the sequencer and the output valid; cell contents are
// left as they are and are never read before being written.
module double_ended_queue_core #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dq_pkg::REQ_DATA_W-1:0]    req_tdata,   // [2:0] action, [34:3] push_value
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dq_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [31:0] out_value, [33:32] status
   output logic                             rsp_tlast
);
   import dq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic               backward_ff, backward_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               accept;
   action_type         action;
   logic [VALUE_W-1:0] push_value;
   logic               is_empty;
   logic               is_full;
   logic [IDX_W-1:0]   tail_idx;
   logic [VALUE_W-1:0] head_value;
   logic [VALUE_W-1:0] tail_value;
   logic [VALUE_W-1:0] inject_value;
   cell_ctrl_type      ctrl;
   logic [VALUE_W-1:0] cell_value [DEPTH];

   // request fields and handshake
   assign action     = action_type'(req_tdata[ACTION_W-1:0]);
   assign push_value = req_tdata[ACTION_W +: VALUE_W];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // front and back of the occupied range
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_FULL);
   assign tail_idx   = IDX_W'(count_ff - CNT_ONE);
   assign head_value = cell_value[0];
   assign tail_value = cell_value[tail_idx];

   // cell row
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [VALUE_W-1:0] left_value;
      logic [VALUE_W-1:0] right_value;

      if (gi == 0) begin : g_first
         assign left_value = inject_value;
      end else begin : g_mid_l
         assign left_value = cell_value[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign right_value = cell_value[gi];
      end else begin : g_mid_r
         assign right_value = cell_value[gi+1];
      end

      dq_cell #(
         .INDEX (gi),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (head_value),
         .push_value  (push_value),
         .value       (cell_value[gi])
      );
   end

   // sequencer: decodes requests and steps listings
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      backward_in   = backward_ff;
      ctrl.op       = CELL_HOLD;
      ctrl.rotate   = 1'b0;
      inject_value  = push_value;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (accept) begin
         case (action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               if (is_full) begin
                  rsp_status_in = STS_FULL;
               end else begin
                  rsp_status_in = STS_OK;
                  ctrl.op       = (action == ACT_PUSH_FRONT) ? CELL_SHIFT_R : CELL_LOAD;
                  count_in      = count_ff + CNT_ONE;
               end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (is_empty) begin
                  rsp_value_in  = '0;
                  rsp_status_in = STS_EMPTY;
               end else begin
                  rsp_status_in = STS_OK;
                  count_in      = count_ff - CNT_ONE;
                  if (action == ACT_POP_FRONT) begin
                     rsp_value_in = head_value;
                     ctrl.op      = CELL_SHIFT_L;
                  end else begin
                     rsp_value_in = tail_value;
                  end
               end
            end
            ACT_LIST_FWD, ACT_LIST_BWD: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = STS_EMPTY;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in    = ST_LIST;
                  remain_in   = count_ff;
                  backward_in = (action == ACT_LIST_BWD);
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end else if (state_ff == ST_LIST && out_free) begin
         // one listed value per step, rotating the occupied range by one cell
         rsp_valid_in  = 1'b1;
         rsp_status_in = STS_OK;
         rsp_last_in   = (remain_ff == CNT_ONE);
         remain_in     = remain_ff - CNT_ONE;
         if (backward_ff) begin
            rsp_value_in = tail_value;
            inject_value = tail_value;
            ctrl.op      = CELL_SHIFT_R;
         end else begin
            rsp_value_in = head_value;
            ctrl.op      = CELL_SHIFT_L;
            ctrl.rotate  = 1'b1;
         end
         if (remain_ff == CNT_ONE) begin
            state_in = ST_IDLE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         backward_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         backward_ff  <= backward_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // result stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W - STATUS_W){1'b0}}, rsp_status_ff, rsp_value_ff};

endmodule
